// File: rtl/core/isort_pkg.sv
// Shared constants for the integer sort engine.
// No dependencies; used by the top level for parameter defaults.
package isort_pkg;

  localparam int unsigned MAX_ITEMS_DEF  = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

endpackage

// File: rtl/core/isort_cell.sv
// One cell of the systolic insertion chain: holds one element, keeps the
// smaller of stored and arriving values and forwards the larger one.
// Standalone; instanced in a row by integer_sort_engine_core.
module isort_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  logic                  ins_valid,
  input  logic [DATA_WIDTH-1:0] ins_data,
  input  logic                  right_occ,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic                  occ,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  fwd_valid,
  output logic [DATA_WIDTH-1:0] fwd_data
);

  logic swap;

  assign swap = $signed(ins_data) < $signed(data);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= 1'b0;
      fwd_valid <= 1'b0;
    end else if (shift) begin
      // drain: move toward the head of the chain
      occ       <= right_occ;
      fwd_valid <= 1'b0;
    end else if (ins_valid) begin
      if (!occ) begin
        occ       <= 1'b1;
        fwd_valid <= 1'b0;
      end else begin
        fwd_valid <= 1'b1;
      end
    end else begin
      fwd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= right_data;
    end else if (ins_valid) begin
      if (!occ) begin
        data <= ins_data;
      end else if (swap) begin
        data     <= ins_data;
        fwd_data <= data;
      end else begin
        fwd_data <= ins_data;
      end
    end
  end

endmodule

// File: rtl/core/integer_sort_engine_core.sv
// Integer sort engine: systolic insertion chain of MAX_ITEMS cells.
// Input: one item per cycle while collecting a set; stalled after the last item.
// After the last item the chain settles in S_SETTLE; S_DRAIN then gives one result
// per cycle while out_stall allows, each result shifting the chain one cell to the head.
// Reset (synchronous) empties the chain, clears the count and the drop flag.
module integer_sort_engine_core #(
  parameter int unsigned MAX_ITEMS  = isort_pkg::MAX_ITEMS_DEF,
  parameter int unsigned DATA_WIDTH = isort_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic                  last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] sorted_value,
  output logic                  final_res,
  output logic                  overflowed
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  typedef enum logic [1:0] {
    S_COLLECT,
    S_SETTLE,
    S_DRAIN
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] settle_cnt;
  logic          dropped;
  logic          accept;
  logic          room;
  logic          load;

  logic                  link_valid [MAX_ITEMS+1];
  logic [DATA_WIDTH-1:0] link_data  [MAX_ITEMS+1];
  logic                  cell_occ   [MAX_ITEMS+1];
  logic [DATA_WIDTH-1:0] cell_data  [MAX_ITEMS+1];

  assign in_stall = (state != S_COLLECT);
  assign accept   = in_valid && !in_stall;
  assign room     = (count != CNT_MAX);
  assign load     = (state == S_DRAIN) && (!out_valid || !out_stall);

  assign link_valid[0]        = accept && room;
  assign link_data[0]         = value;
  assign cell_occ[MAX_ITEMS]  = 1'b0;
  assign cell_data[MAX_ITEMS] = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    isort_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (load),
      .ins_valid (link_valid[i]),
      .ins_data  (link_data[i]),
      .right_occ (cell_occ[i+1]),
      .right_data(cell_data[i+1]),
      .occ       (cell_occ[i]),
      .data      (cell_data[i]),
      .fwd_valid (link_valid[i+1]),
      .fwd_data  (link_data[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_COLLECT;
      count      <= '0;
      settle_cnt <= '0;
      dropped    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_COLLECT: begin
          if (accept) begin
            if (room) begin
              count <= count + CNT_ONE;
            end else begin
              dropped <= 1'b1;
            end
            if (last) begin
              settle_cnt <= CNT_MAX;
              state      <= S_SETTLE;
            end
          end
        end
        S_SETTLE: begin
          // let every element in flight reach its cell
          settle_cnt <= settle_cnt - CNT_ONE;
          if (settle_cnt == CNT_ONE) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (load) begin
            out_valid    <= 1'b1;
            sorted_value <= cell_data[0];
            final_res    <= (count == CNT_ONE);
            overflowed   <= dropped;
            count        <= count - CNT_ONE;
            if (count == CNT_ONE) begin
              dropped <= 1'b0;
              state   <= S_COLLECT;
            end
          end
        end
        default: begin
          state <= S_COLLECT;
        end
      endcase
    end
  end

endmodule
